>>> rtl/esic_pkg.sv
// esic_pkg: shared types and constants for the sensor compensation block
// no dependencies
`timescale 1ns / 1ps
package esic_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned DivW     = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TEMP_CAL    = 3'd0,
    REG_PRESS_CAL_A = 3'd1,
    REG_PRESS_CAL_B = 3'd2,
    REG_PRESS_CAL_C = 3'd3,
    REG_HUM_CAL     = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] temp_centi_c;
    logic signed [31:0] fine_temp;
    logic        [31:0] press_q24_8;
    logic               press_valid;
    logic        [16:0] hum_q22_10;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_item_t;

  // calibration words, already unpacked
  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
    logic        [7:0]  h1;
    logic signed [15:0] h2;
    logic        [7:0]  h3;
    logic signed [11:0] h4;
    logic signed [11:0] h5;
    logic signed [7:0]  h6;
  } cal_t;

  localparam logic signed [63:0] PressOffs = 64'sd128000;
  localparam logic signed [31:0] HumOffs   = 32'sd76800;
  localparam logic [31:0]        HumMax    = 32'd419430400;

endpackage

>>> rtl/esic_if.sv
// esic_stream_if: valid/ready channel carrying one payload of a given type
// depends on nothing; payload type chosen at instantiation
`timescale 1ns / 1ps
interface esic_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/esic_cfg.sv
// esic_cfg: calibration register file written over the configuration channel
// depends on esic_pkg and esic_stream_if
`timescale 1ns / 1ps
module esic_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  esic_stream_if.sink       cfg,
  output esic_pkg::cal_t    cal_o
);
  logic [47:0] temp_q;
  logic [63:0] pa_q, pb_q, hum_q;
  logic [15:0] pc_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= '0; pa_q <= '0; pb_q <= '0; pc_q <= '0; hum_q <= '0;
    end else if (cfg.valid) begin
      case (cfg.data.idx)
        esic_pkg::REG_TEMP_CAL:    temp_q <= cfg.data.data[47:0];
        esic_pkg::REG_PRESS_CAL_A: pa_q   <= cfg.data.data;
        esic_pkg::REG_PRESS_CAL_B: pb_q   <= cfg.data.data;
        esic_pkg::REG_PRESS_CAL_C: pc_q   <= cfg.data.data[15:0];
        esic_pkg::REG_HUM_CAL:     hum_q  <= cfg.data.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cal_o.t1 = temp_q[15:0];  cal_o.t2 = temp_q[31:16]; cal_o.t3 = temp_q[47:32];
    cal_o.p1 = pa_q[15:0];    cal_o.p2 = pa_q[31:16];   cal_o.p3 = pa_q[47:32];
    cal_o.p4 = pa_q[63:48];
    cal_o.p5 = pb_q[15:0];    cal_o.p6 = pb_q[31:16];   cal_o.p7 = pb_q[47:32];
    cal_o.p8 = pb_q[63:48];   cal_o.p9 = pc_q;
    cal_o.h1 = hum_q[7:0];    cal_o.h2 = hum_q[23:8];   cal_o.h3 = hum_q[31:24];
    cal_o.h4 = hum_q[43:32];  cal_o.h5 = hum_q[55:44];  cal_o.h6 = hum_q[63:56];
  end
endmodule

>>> rtl/esic_div.sv
// esic_div: pipelined signed 64-bit divider, one quotient bit per stage
// depends on esic_pkg; truncates toward zero, zero divisor gives zero
`timescale 1ns / 1ps
module esic_div #(
  parameter int unsigned W = esic_pkg::DivW,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [W-1:0]  num_i,
  input  logic [W-1:0]  den_i,
  input  logic [SW-1:0] side_i,
  output logic [W-1:0]  quo_o,
  output logic [SW-1:0] side_o
);
  logic [W-1:0]  rem_q [W+1];
  logic [W-1:0]  quo_q [W+1];
  logic [W-1:0]  num_q [W+1];
  logic [W-1:0]  den_q [W+1];
  logic          neg_q [W+1];
  logic [SW-1:0] side_q [W+1];

  // magnitudes on entry
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q[0]  <= num_i[W-1] ? -num_i : num_i;
      den_q[0]  <= den_i[W-1] ? -den_i : den_i;
      neg_q[0]  <= num_i[W-1] ^ den_i[W-1];
      rem_q[0]  <= '0;
      quo_q[0]  <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic [W:0]   trial;
    logic [W-1:0] rsh;
    assign rsh   = {rem_q[s][W-2:0], num_q[s][W-1-s]};
    assign trial = {rem_q[s][W-1], rsh} - {1'b0, den_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!trial[W] && den_q[s] != '0) begin
          rem_q[s+1] <= trial[W-1:0];
          quo_q[s+1] <= quo_q[s] | (W'(1) << (W-1-s));
        end else begin
          rem_q[s+1] <= rsh;
          quo_q[s+1] <= quo_q[s];
        end
        num_q[s+1]  <= num_q[s];
        den_q[s+1]  <= den_q[s];
        neg_q[s+1]  <= neg_q[s];
        side_q[s+1] <= side_q[s];
      end
    end
  end

  assign quo_o  = neg_q[W] ? -quo_q[W] : quo_q[W];
  assign side_o = side_q[W];
endmodule

>>> rtl/esic_core.sv
// esic_core: stall-controlled compensation pipeline (temperature, pressure, humidity)
// depends on esic_pkg and esic_div
`timescale 1ns / 1ps
module esic_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                in_valid_i,
  input  esic_pkg::in_item_t  in_i,
  input  esic_pkg::cal_t      cal_i,
  output logic                out_valid_o,
  output esic_pkg::out_item_t out_o
);
  localparam int unsigned DivLat = esic_pkg::DivW + 1;
  localparam int unsigned NPre = 9;
  localparam int unsigned NPost = 6;
  localparam int unsigned NV = NPre + DivLat + NPost;

  // payload carried past the divider
  typedef struct packed {
    logic signed [31:0] tc;
    logic signed [31:0] tf;
    logic               pvalid;
    logic        [16:0] hum;
  } side_t;

  logic [NV-1:0] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en_i) v_q <= {v_q[NV-2:0], in_valid_i};
  end

  // stage 1: temperature products
  logic signed [31:0] s1_v1m, s1_d;
  logic        [19:0] s1_rp;
  logic        [15:0] s1_rh;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_v1m <= (32'({12'd0, in_i.raw_temp} >> 3) - {15'd0, cal_i.t1, 1'b0})
                * 32'(cal_i.t2);
      s1_d   <= 32'({12'd0, in_i.raw_temp} >> 4) - {16'd0, cal_i.t1};
      s1_rp  <= in_i.raw_press;
      s1_rh  <= in_i.raw_hum;
    end
  end

  // stage 2
  logic signed [31:0] s2_v1, s2_dd;
  logic        [19:0] s2_rp;
  logic        [15:0] s2_rh;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_v1 <= s1_v1m >>> 11;
      s2_dd <= s1_d * s1_d;
      s2_rp <= s1_rp; s2_rh <= s1_rh;
    end
  end

  // stage 3
  logic signed [31:0] s3_v1, s3_v2m;
  logic        [19:0] s3_rp;
  logic        [15:0] s3_rh;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_v1  <= s2_v1;
      s3_v2m <= (s2_dd >>> 12) * 32'(cal_i.t3);
      s3_rp <= s2_rp; s3_rh <= s2_rh;
    end
  end

  // stage 4: fine temperature
  logic signed [31:0] s4_tf;
  logic        [19:0] s4_rp;
  logic        [15:0] s4_rh;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_tf <= s3_v1 + (s3_v2m >>> 14);
      s4_rp <= s3_rp; s4_rh <= s3_rh;
    end
  end

  // stage 5: first products
  logic signed [31:0] s5_tf, s5_tc, s5_ha, s5_hb, s5_hc;
  logic signed [63:0] s5_aa, s5_ap5, s5_ap2;
  logic        [19:0] s5_rp;
  logic signed [32:0] a4;
  logic signed [31:0] x4;
  // fine temperature minus offset always fits 33 bits
  assign a4 = {s4_tf[31], s4_tf} - 33'(esic_pkg::PressOffs);
  assign x4 = s4_tf - esic_pkg::HumOffs;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_tf  <= s4_tf;
      s5_tc  <= (s4_tf * 32'sd5 + 32'sd128) >>> 8;
      s5_aa  <= a4 * a4;
      s5_ap5 <= a4 * 64'(cal_i.p5);
      s5_ap2 <= a4 * 64'(cal_i.p2);
      s5_ha  <= (32'({16'd0, s4_rh}) <<< 14) - (32'(cal_i.h4) <<< 20)
                - 32'(cal_i.h5) * x4 + 32'sd16384;
      s5_hb  <= (x4 * 32'(cal_i.h6)) >>> 10;
      s5_hc  <= ((x4 * $signed({24'd0, cal_i.h3})) >>> 11) + 32'sd32768;
      s5_rp  <= s4_rp;
    end
  end

  // stage 6
  logic signed [31:0] s6_tf, s6_tc, s6_ha, s6_he;
  logic signed [63:0] s6_b, s6_a;
  logic        [19:0] s6_rp;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s6_tf <= s5_tf; s6_tc <= s5_tc;
      s6_b  <= s5_aa * 64'(cal_i.p6) + (s5_ap5 <<< 17) + (64'(cal_i.p4) <<< 35);
      s6_a  <= ((s5_aa * 64'(cal_i.p3)) >>> 8) + (s5_ap2 <<< 12);
      s6_ha <= s5_ha >>> 15;
      s6_he <= ((s5_hb * s5_hc) >>> 10) + 32'sd2097152;
      s6_rp <= s5_rp;
    end
  end

  // stage 7
  logic signed [31:0] s7_tf, s7_tc, s7_ha, s7_hg;
  logic signed [63:0] s7_b, s7_a, s7_n;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s7_tf <= s6_tf; s7_tc <= s6_tc;
      s7_b  <= s6_b;
      s7_a  <= (((64'sd1 <<< 47) + s6_a) * $signed({48'd0, cal_i.p1})) >>> 33;
      s7_n  <= (64'sd1048576 - $signed({44'd0, s6_rp})) <<< 31;
      s7_ha <= s6_ha;
      s7_hg <= (s6_he * 32'(cal_i.h2) + 32'sd8192) >>> 14;
    end
  end

  // stage 8
  logic signed [31:0] s8_tf, s8_tc, s8_x;
  logic signed [63:0] s8_a, s8_num;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s8_tf  <= s7_tf; s8_tc <= s7_tc;
      s8_a   <= s7_a;
      s8_num <= (s7_n - s7_b) * 64'sd3125;
      s8_x   <= s7_ha * s7_hg;
    end
  end

  // stage 9: humidity finish
  logic signed [31:0] s9_tf, s9_tc, s9_x, s9_sq;
  logic signed [63:0] s9_a, s9_num;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s9_tf <= s8_tf; s9_tc <= s8_tc; s9_a <= s8_a; s9_num <= s8_num;
      s9_x  <= s8_x;
      s9_sq <= ((s8_x >>> 15) * (s8_x >>> 15)) >>> 7;
    end
  end

  logic signed [31:0] hx;
  logic        [16:0] hq;
  assign hx = s9_x - (((s9_sq * $signed({24'd0, cal_i.h1}))) >>> 4);
  always_comb begin
    if (hx[31]) hq = '0;
    else if ($unsigned(hx) > esic_pkg::HumMax) hq = 17'(esic_pkg::HumMax >> 12);
    else hq = hx[28:12];
  end

  side_t div_si, div_so;
  logic [63:0] quo;
  assign div_si = '{tc: s9_tc, tf: s9_tf, pvalid: (s9_a != '0), hum: hq};

  esic_div #(.W(esic_pkg::DivW), .SW($bits(side_t))) u_div (
    .clk_i, .en_i,
    .num_i(s9_num), .den_i(s9_a), .side_i(div_si),
    .quo_o(quo), .side_o(div_so)
  );

  // post-divide stages
  side_t t1_s, t2_s, t3_s, t4_s, t5_s, t6_s;
  logic signed [63:0] t1_p, t1_q13, t2_p, t2_a, t2_b, t2_q13;
  logic signed [63:0] t3_p, t3_b, t4_pb, t4_m, t5_p;
  logic        [63:0] t3_ml;
  logic        [31:0] t3_mx;
  logic        [31:0] t6_ps;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_s <= div_so; t1_p <= quo; t1_q13 <= $signed(quo) >>> 13;
      t2_s <= t1_s; t2_p <= t1_p; t2_q13 <= t1_q13;
      t2_a <= 64'(cal_i.p9) * t1_q13;
      t2_b <= (64'(cal_i.p8) * t1_p) >>> 19;
      // low 64 bits of the wide product from 32-bit partial products
      t3_s  <= t2_s; t3_p <= t2_p; t3_b <= t2_b;
      t3_ml <= t2_a[31:0] * t2_q13[31:0];
      t3_mx <= t2_a[63:32] * t2_q13[31:0] + t2_a[31:0] * t2_q13[63:32];
      t4_s  <= t3_s;
      t4_pb <= t3_p + t3_b;
      t4_m  <= $signed(t3_ml + {t3_mx, 32'd0});
      t5_s  <= t4_s;
      t5_p  <= ((t4_pb + (t4_m >>> 25)) >>> 8) + (64'(cal_i.p7) <<< 4);
      t6_s  <= t5_s;
      if (!t5_s.pvalid || t5_p[63]) t6_ps <= '0;
      else if (t5_p[62:32] != '0) t6_ps <= '1;
      else t6_ps <= t5_p[31:0];
    end
  end

  assign out_valid_o = v_q[NV-1];
  assign out_o = '{temp_centi_c: t6_s.tc, fine_temp: t6_s.tf, press_q24_8: t6_ps,
                   press_valid: t6_s.pvalid, hum_q22_10: t6_s.hum};
endmodule

>>> rtl/env_sensor_integer_compensation.sv
// env_sensor_integer_compensation: top level, config registers and stall-controlled pipeline
// depends on esic_pkg, esic_stream_if, esic_cfg, esic_core
`timescale 1ns / 1ps
// Usage:
//   in   : raw sample triple (raw_temp, raw_press, raw_hum), valid/ready
//   out  : temp_centi_c, fine_temp, press_q24_8, press_valid, hum_q22_10
//   cfg  : register index and 64-bit data; always ready, write only while idle
// One sample is taken per cycle unless stalled; results leave in order, one per sample.
// The pipeline has nine arithmetic stages, 65 stages of the pipelined
// 64-bit signed divider (one quotient bit each after the entry stage) and six
// pressure finish stages. The whole pipeline advances together as one stall domain.
// Throughput is one transaction per cycle while the receiver takes results.
// When the receiver stalls a waiting result, it holds and the pipeline freezes;
// in.ready follows out.ready or an empty output slot, so nothing is lost.
// Reset clears all calibration registers to zero and all valid bits; no
// clearing pass is needed.
module env_sensor_integer_compensation (
  input  logic         clk_i,
  input  logic         rst_ni,
  esic_stream_if.sink  in_ch,
  esic_stream_if.source out_ch,
  esic_stream_if.sink  cfg_ch
);
  esic_pkg::cal_t      cal;
  esic_pkg::out_item_t core_out;
  logic                core_valid, en;

  esic_cfg u_cfg (.clk_i, .rst_ni, .cfg(cfg_ch), .cal_o(cal));

  // pipeline moves when the last stage is empty or being drained
  assign en           = !core_valid || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = core_valid;
  assign out_ch.data  = core_out;

  esic_core u_core (
    .clk_i, .rst_ni, .en_i(en),
    .in_valid_i(in_ch.valid), .in_i(in_ch.data), .cal_i(cal),
    .out_valid_o(core_valid), .out_o(core_out)
  );

`ifndef SYNTH
  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> out_ch.data.hum_q22_10 <= 17'd102400)
    else $error("humidity above clamp");
  a_press_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.data.press_valid) |-> out_ch.data.press_q24_8 == '0)
    else $error("pressure nonzero with invalid flag");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(out_ch.data))
    else $error("stalled result changed");
`endif
endmodule

>>> bench/esic_checker.sv
// esic_checker: watches the sample, result and calibration channels of the compensation block
// predicts each result from its own copy of the calibration words; depends on esic_pkg, esic_stream_if
`timescale 1ns / 1ps
module esic_checker (
  input  logic clk_i,
  input  logic rst_ni,
  esic_stream_if in_ch,
  esic_stream_if out_ch,
  esic_stream_if cfg_ch,
  output int   fail_count_o,
  output int   pending_o
);

  logic [63:0] temp_cal_q, press_a_q, press_b_q, press_c_q, hum_cal_q;
  esic_pkg::out_item_t comp_q[$];

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  // integer compensation of one sample triple with the current calibration words
  function automatic esic_pkg::out_item_t compensate(input esic_pkg::in_item_t s);
    esic_pkg::out_item_t r;
    logic signed [31:0] t1, t2, t3, at, d, v1, v2, tf, tc;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, p, num, pa, pb;
    logic signed [31:0] h1, h2, h3, h4, h5, h6, ah, x, ha, hb, hc, he, hg, y;
    t1 = {16'b0, temp_cal_q[15:0]};
    t2 = {{16{temp_cal_q[31]}}, temp_cal_q[31:16]};
    t3 = {{16{temp_cal_q[47]}}, temp_cal_q[47:32]};
    at = {12'b0, s.raw_temp};
    v1 = (at >>> 3) - (t1 <<< 1);
    v1 = (v1 * t2) >>> 11;
    d  = (at >>> 4) - t1;
    v2 = (d * d) >>> 12;
    v2 = (v2 * t3) >>> 14;
    tf = v1 + v2;
    tc = (tf * 5 + 128) >>> 8;

    p1 = {48'b0, press_a_q[15:0]};
    p2 = {{48{press_a_q[31]}}, press_a_q[31:16]};
    p3 = {{48{press_a_q[47]}}, press_a_q[47:32]};
    p4 = {{48{press_a_q[63]}}, press_a_q[63:48]};
    p5 = {{48{press_b_q[15]}}, press_b_q[15:0]};
    p6 = {{48{press_b_q[31]}}, press_b_q[31:16]};
    p7 = {{48{press_b_q[47]}}, press_b_q[47:32]};
    p8 = {{48{press_b_q[63]}}, press_b_q[63:48]};
    p9 = {{48{press_c_q[15]}}, press_c_q[15:0]};
    a = tf;
    a = a - 64'sd128000;
    b = a * a * p6;
    b = b + ((a * p5) <<< 17);
    b = b + (p4 <<< 35);
    a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
    a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
    r.press_valid = (a != 0);
    if (a == 0) begin
      r.press_q24_8 = '0;
    end else begin
      p   = 64'sd1048576 - $signed({44'b0, s.raw_press});
      num = ((p <<< 31) - b) * 64'sd3125;
      // most negative over minus one wraps to itself
      if (num == {1'b1, 63'b0} && a == -64'sd1) p = num;
      else p = num / a;
      pa = ((p9 * (p >>> 13)) * (p >>> 13)) >>> 25;
      pb = (p8 * p) >>> 19;
      p  = ((p + pa + pb) >>> 8) + (p7 <<< 4);
      if (p < 0) r.press_q24_8 = '0;
      else if (p > 64'sd4294967295) r.press_q24_8 = '1;
      else r.press_q24_8 = p[31:0];
    end

    h1 = {24'b0, hum_cal_q[7:0]};
    h2 = {{16{hum_cal_q[23]}}, hum_cal_q[23:8]};
    h3 = {24'b0, hum_cal_q[31:24]};
    h4 = {{20{hum_cal_q[43]}}, hum_cal_q[43:32]};
    h5 = {{20{hum_cal_q[55]}}, hum_cal_q[55:44]};
    h6 = {{24{hum_cal_q[63]}}, hum_cal_q[63:56]};
    ah = {16'b0, s.raw_hum};
    x  = tf - 32'sd76800;
    ha = ((ah <<< 14) - (h4 <<< 20) - h5 * x + 32'sd16384) >>> 15;
    hb = (x * h6) >>> 10;
    hc = ((x * h3) >>> 11) + 32'sd32768;
    he = ((hb * hc) >>> 10) + 32'sd2097152;
    hg = (he * h2 + 32'sd8192) >>> 14;
    x  = ha * hg;
    y  = ((x >>> 15) * (x >>> 15)) >>> 7;
    y  = (y * h1) >>> 4;
    x  = x - y;
    if (x < 0) x = 0;
    else if (x > 32'sd419430400) x = 32'sd419430400;
    r.hum_q22_10   = x[28:12];
    r.temp_centi_c = tc;
    r.fine_temp    = tf;
    return r;
  endfunction

  assign pending_o = comp_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    esic_pkg::out_item_t want;
    if (!rst_ni) begin
      temp_cal_q   <= '0;
      press_a_q    <= '0;
      press_b_q    <= '0;
      press_c_q    <= '0;
      hum_cal_q    <= '0;
      fail_count_o = 0;
      comp_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) comp_q.push_back(compensate(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        if (comp_q.size() == 0) begin
          $display("unexpected result transaction at %0t", $realtime);
          fail_count_o++;
        end else begin
          want = comp_q.pop_front();
          if (out_ch.data.temp_centi_c !== want.temp_centi_c)
            report_mismatch("temp_centi_c", out_ch.data.temp_centi_c, want.temp_centi_c);
          if (out_ch.data.fine_temp !== want.fine_temp)
            report_mismatch("fine_temp", out_ch.data.fine_temp, want.fine_temp);
          if (out_ch.data.press_q24_8 !== want.press_q24_8)
            report_mismatch("press_q24_8", out_ch.data.press_q24_8, want.press_q24_8);
          if (out_ch.data.press_valid !== want.press_valid)
            report_mismatch("press_valid", out_ch.data.press_valid, want.press_valid);
          if (out_ch.data.hum_q22_10 !== want.hum_q22_10)
            report_mismatch("hum_q22_10", out_ch.data.hum_q22_10, want.hum_q22_10);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.data.idx)
          esic_pkg::REG_TEMP_CAL:    temp_cal_q <= {16'b0, cfg_ch.data.data[47:0]};
          esic_pkg::REG_PRESS_CAL_A: press_a_q  <= cfg_ch.data.data;
          esic_pkg::REG_PRESS_CAL_B: press_b_q  <= cfg_ch.data.data;
          esic_pkg::REG_PRESS_CAL_C: press_c_q  <= {48'b0, cfg_ch.data.data[15:0]};
          esic_pkg::REG_HUM_CAL:     hum_cal_q  <= cfg_ch.data.data;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> bench/env_sensor_integer_compensation_tb.sv
// env_sensor_integer_compensation_tb: stimulus, calibration phases and verdict
// depends on esic_pkg, esic_stream_if, the compensation block and esic_checker
`timescale 1ns / 1ps
module env_sensor_integer_compensation_tb;

  localparam int Latency   = 80;
  localparam int CycleCap  = 600000;
  localparam int NumPhases = 6;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, cycles;
  int   send_idle_pct, recv_stall_pct, hold_off;

  esic_stream_if #(.T(esic_pkg::in_item_t))  in_ch ();
  esic_stream_if #(.T(esic_pkg::out_item_t)) out_ch ();
  esic_stream_if #(.T(esic_pkg::cfg_item_t)) cfg_ch ();

  env_sensor_integer_compensation u_top (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_ch (in_ch), .out_ch (out_ch), .cfg_ch (cfg_ch)
  );

  esic_checker u_checker (
    .clk_i (clk_i), .rst_ni (rst_ni), .in_ch (in_ch), .out_ch (out_ch), .cfg_ch (cfg_ch),
    .fail_count_o (fail_count), .pending_o (pending)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleCap) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // receiver: random stalls, or a long hold-off while the sender keeps going
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off > 0) begin
        out_ch.ready <= 1'b0;
        hold_off--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_sample(input esic_pkg::in_item_t s);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= s;
    do begin
      @(negedge clk_i);
      took = in_ch.valid && in_ch.ready;
      @(posedge clk_i);
    end while (!took);
  endtask

  task automatic write_reg(input esic_pkg::reg_idx_e idx, input logic [63:0] value);
    logic took;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{idx: idx, data: value};
    do begin
      @(negedge clk_i);
      took = cfg_ch.ready;
      @(posedge clk_i);
    end while (!took);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic load_calibration(input int phase);
    case (phase)
      1: begin
        // typical factory words
        write_reg(esic_pkg::REG_TEMP_CAL, {16'(-1000), 16'sd26435, 16'd27504});
        write_reg(esic_pkg::REG_PRESS_CAL_A,
                  {16'sd2855, 16'sd3024, 16'(-10685), 16'd36477});
        write_reg(esic_pkg::REG_PRESS_CAL_B, {16'(-14600), 16'sd15500, 16'(-7), 16'sd140});
        write_reg(esic_pkg::REG_PRESS_CAL_C, 64'd6000);
        write_reg(esic_pkg::REG_HUM_CAL,
                  {8'sd30, 12'd50, 12'd313, 8'd0, 16'sd362, 8'd75});
      end
      2: begin
        write_reg(esic_pkg::REG_TEMP_CAL, 64'hFFFF_FFFF_FFFF);
        write_reg(esic_pkg::REG_PRESS_CAL_A, '1);
        write_reg(esic_pkg::REG_PRESS_CAL_B, '1);
        write_reg(esic_pkg::REG_PRESS_CAL_C, 64'hFFFF);
        write_reg(esic_pkg::REG_HUM_CAL, '1);
      end
      4: begin
        write_reg(esic_pkg::REG_TEMP_CAL, 64'h8000_7FFF_FFFF);
        write_reg(esic_pkg::REG_PRESS_CAL_A, 64'h7FFF_8000_7FFF_FFFF);
        write_reg(esic_pkg::REG_PRESS_CAL_B, 64'h8000_7FFF_8000_7FFF);
        write_reg(esic_pkg::REG_PRESS_CAL_C, 64'h8000);
        write_reg(esic_pkg::REG_HUM_CAL, 64'h7F80_07FF_FF80_00FF);
      end
      default: begin
        write_reg(esic_pkg::REG_TEMP_CAL, {16'b0, 48'(rand64())});
        write_reg(esic_pkg::REG_PRESS_CAL_A, rand64());
        write_reg(esic_pkg::REG_PRESS_CAL_B, rand64());
        write_reg(esic_pkg::REG_PRESS_CAL_C, {48'b0, 16'($urandom())});
        write_reg(esic_pkg::REG_HUM_CAL, rand64());
      end
    endcase
  endtask

  initial begin
    esic_pkg::in_item_t s;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off       = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // phase 0 runs on reset calibration: divisor zero, pressure flagged
    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase != 0) load_calibration(phase);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 9; recv_stall_pct = 9; end
      endcase
      // field extremes
      for (int k = 0; k < 8; k++) begin
        s.raw_temp  = k[0] ? '1 : '0;
        s.raw_press = k[1] ? '1 : '0;
        s.raw_hum   = k[2] ? '1 : '0;
        send_sample(s);
      end
      send_sample('{raw_temp: 20'h80000, raw_press: 20'h80000, raw_hum: 16'h8000});
      send_sample('{raw_temp: 20'h7FFFF, raw_press: 20'h7FFFF, raw_hum: 16'h7FFF});
      send_sample('{raw_temp: 20'd519888, raw_press: 20'd415148, raw_hum: 16'd30000});
      if (phase == 1) hold_off = 400;
      for (int n = 0; n < 300; n++) begin
        if ($urandom_range(3) == 0) begin
          s = '{raw_temp: 20'($urandom()), raw_press: 20'($urandom()),
                raw_hum: 16'($urandom())};
        end else begin
          // plausible conversion range for a working sensor
          s.raw_temp  = 20'($urandom_range(600000, 420000));
          s.raw_press = 20'($urandom_range(500000, 250000));
          s.raw_hum   = 16'($urandom_range(50000, 15000));
        end
        send_sample(s);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/esic_pkg.sv
rtl/esic_if.sv
rtl/esic_cfg.sv
rtl/esic_div.sv
rtl/esic_core.sv
rtl/env_sensor_integer_compensation.sv
bench/esic_checker.sv
bench/env_sensor_integer_compensation_tb.sv
